/* design/kste_pkg.sv */
// Shared types and constants for the keypress sequence timing extractor.
// No dependencies; every other file imports this package.
package kste_pkg;

   localparam int SEQ_LEN       = 4;
   localparam int BUTTON_COUNT  = 4;
   localparam int STAMP_BITS    = 40;
   localparam int BUTTON_BITS   = 2;
   localparam int FEAT_BITS     = 16;
   localparam int SEQ_CFG_BITS  = 8;
   localparam int SEQ_SLOT_BITS = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int KIND_BITS     = 2;
   localparam int POS_BITS      = $clog2(SEQ_LEN);
   localparam int FEAT_COUNT    = 2 * SEQ_LEN - 1;
   localparam int FEAT_IDX_BITS = $clog2(FEAT_COUNT);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [FEAT_BITS-1:0]    DEBOUNCE_RESET = 16'd50;
   localparam logic [FEAT_BITS-1:0]    FEAT_MIN_RESET = 16'd5;
   localparam logic [FEAT_BITS-1:0]    FEAT_MAX_RESET = 16'd5000;
   localparam logic [SEQ_CFG_BITS-1:0] EXP_SEQ_RESET  = 8'd228;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_FEATURE = 2'd0,
      KIND_BAD     = 2'd1,
      KIND_WRONG   = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DEBOUNCE = 2'd0,
      CSR_FEAT_MIN = 2'd1,
      CSR_FEAT_MAX = 2'd2,
      CSR_EXP_SEQ  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FEAT_BITS-1:0]    debounce_gap;
      logic [FEAT_BITS-1:0]    feat_min;
      logic [FEAT_BITS-1:0]    feat_max;
      logic [SEQ_CFG_BITS-1:0] exp_seq;
   } cfg_type;

   typedef struct packed {
      kind_type                             kind;
      logic [BUTTON_BITS-1:0]               exp_button;
      logic [FEAT_COUNT-1:0][FEAT_BITS-1:0] feat;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } q_wr_type;

   typedef struct packed {
      logic    empty;
      job_type head;
   } q_rd_type;

endpackage

/* design/kste_front.sv */
// Front end: takes button edge requests, tracks position, debounce and stamps,
// and queues a job for every request that yields results. Uses kste_pkg.
module kste_front (
   input  logic                              clock,
   input  logic                              reset,
   input  kste_pkg::cfg_type                 cfg,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [kste_pkg::BUTTON_BITS-1:0]  req_button,
   input  logic                              req_pressed,
   input  logic [kste_pkg::STAMP_BITS-1:0]   req_time_ms,
   input  logic                              q_full,
   output kste_pkg::q_wr_type                q_wr
);
   import kste_pkg::*;

   typedef struct packed {
      logic                 ok;
      logic [FEAT_BITS-1:0] val;
   } chk_type;

   function automatic chk_type interval_chk(input logic [STAMP_BITS-1:0] a,
                                            input logic [STAMP_BITS-1:0] b,
                                            input logic [FEAT_BITS-1:0]  lo,
                                            input logic [FEAT_BITS-1:0]  hi);
      logic [STAMP_BITS:0] d;
      chk_type             r;
      d     = {1'b0, b} - {1'b0, a};
      r.val = d[FEAT_BITS-1:0];
      r.ok  = !d[STAMP_BITS] && (d[STAMP_BITS-1:0] > STAMP_BITS'(lo))
              && (d[STAMP_BITS-1:0] <= STAMP_BITS'(hi));
      return r;
   endfunction

   // Slots beyond the register expect button zero.
   function automatic logic [BUTTON_BITS-1:0] expected_at(
         input logic [SEQ_CFG_BITS-1:0] seq, input logic [POS_BITS-1:0] pos);
      logic [SEQ_CFG_BITS+SEQ_SLOT_BITS*SEQ_LEN-1:0] ext;
      ext = {{(SEQ_SLOT_BITS*SEQ_LEN){1'b0}}, seq};
      return BUTTON_BITS'(ext[pos*SEQ_SLOT_BITS +: SEQ_SLOT_BITS]);
   endfunction

   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [SEQ_LEN-1:0]    seen_ff, seen_in;
   logic [STAMP_BITS-1:0] last_edge_ff [BUTTON_COUNT];
   logic [STAMP_BITS-1:0] press_ff [SEQ_LEN];
   logic [STAMP_BITS-1:0] rel_ff [SEQ_LEN];

   logic                   accept, btn_in_range, wrong, too_soon, take;
   logic                   press_wr, release_wr, at_end, done, all_ok;
   logic [BUTTON_BITS-1:0] exp_btn;
   logic [STAMP_BITS:0]    edge_diff;
   chk_type                chk [FEAT_COUNT];

   assign req_full     = q_full;
   assign accept       = req_push && !q_full;
   assign btn_in_range = (32'(req_button) < BUTTON_COUNT);
   assign exp_btn      = expected_at(cfg.exp_seq, pos_ff);
   assign wrong        = (req_button != exp_btn);
   assign edge_diff    = {1'b0, req_time_ms} - {1'b0, last_edge_ff[req_button]};
   assign too_soon     = edge_diff[STAMP_BITS]
                         || (edge_diff[STAMP_BITS-1:0] < STAMP_BITS'(cfg.debounce_gap));
   assign take         = accept && btn_in_range && !wrong && !too_soon;
   assign press_wr     = take && req_pressed;
   assign release_wr   = take && !req_pressed && seen_ff[pos_ff];
   assign at_end       = (pos_ff == POS_BITS'(SEQ_LEN - 1));
   assign done         = release_wr && at_end;

   // Holds first, then flights; the final release stamp is the current request.
   always_comb begin
      all_ok = 1'b1;
      for (int i = 0; i < SEQ_LEN; i++) begin
         chk[i] = interval_chk(press_ff[i],
                               (i == SEQ_LEN - 1) ? req_time_ms : rel_ff[i],
                               cfg.feat_min, cfg.feat_max);
      end
      for (int i = 0; i < SEQ_LEN - 1; i++) begin
         chk[SEQ_LEN + i] = interval_chk(rel_ff[i], press_ff[i + 1],
                                         cfg.feat_min, cfg.feat_max);
      end
      for (int i = 0; i < FEAT_COUNT; i++) begin
         all_ok = all_ok && chk[i].ok;
      end
   end

   always_comb begin
      pos_in  = pos_ff;
      seen_in = seen_ff;
      if (accept && btn_in_range && wrong) begin
         pos_in = '0;
      end else if (release_wr) begin
         pos_in = at_end ? '0 : pos_ff + 1'b1;
      end
      if (done) begin
         seen_in = '0;
      end else if (press_wr) begin
         seen_in[pos_ff] = 1'b1;
      end
   end

   always_comb begin
      q_wr.push = accept && btn_in_range && (wrong || done);
      if (wrong) begin
         q_wr.job.kind       = KIND_WRONG;
         q_wr.job.exp_button = exp_btn;
      end else begin
         q_wr.job.kind       = all_ok ? KIND_FEATURE : KIND_BAD;
         q_wr.job.exp_button = '0;
      end
      for (int i = 0; i < FEAT_COUNT; i++) begin
         q_wr.job.feat[i] = chk[i].val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         seen_ff <= '0;
         for (int i = 0; i < BUTTON_COUNT; i++) begin
            last_edge_ff[i] <= '0;
         end
      end else begin
         pos_ff  <= pos_in;
         seen_ff <= seen_in;
         if (take) begin
            last_edge_ff[req_button] <= req_time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (press_wr) begin
         press_ff[pos_ff] <= req_time_ms;
      end
      if (release_wr) begin
         rel_ff[pos_ff] <= req_time_ms;
      end
   end

endmodule

/* design/kste_queue.sv */
// Short job queue between front and back ends.
// Uses kste_pkg for the job and port structs.
module kste_queue (
   input  logic               clock,
   input  logic               reset,
   input  kste_pkg::q_wr_type q_wr,
   output logic               q_full,
   input  logic               q_pop,
   output kste_pkg::q_rd_type q_rd
);
   import kste_pkg::*;

   job_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push, do_pop;

   assign q_full     = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign q_rd.empty = (count_ff == '0);
   assign q_rd.head  = mem_ff[rd_ptr_ff];
   assign do_push    = q_wr.push && !q_full;
   assign do_pop     = q_pop && !q_rd.empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_wr.job;
      end
   end

endmodule

/* design/kste_back.sv */
// Back end: expands queued jobs into result items through an output register,
// one per cycle unless the result side stalls. Uses kste_pkg.
module kste_back (
   input  logic                               clock,
   input  logic                               reset,
   input  kste_pkg::q_rd_type                 q_rd,
   output logic                               q_pop,
   input  logic                               rsp_pop,
   output logic                               rsp_empty,
   output logic [kste_pkg::KIND_BITS-1:0]     rsp_result_kind,
   output logic [kste_pkg::FEAT_IDX_BITS-1:0] rsp_feature_index,
   output logic [kste_pkg::FEAT_BITS-1:0]     rsp_feature_value,
   output logic [kste_pkg::BUTTON_BITS-1:0]   rsp_expected_button,
   output logic                               rsp_last_item
);
   import kste_pkg::*;

   logic [FEAT_IDX_BITS-1:0] idx_ff, idx_in;
   logic                     out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]     kind_ff;
   logic [FEAT_IDX_BITS-1:0] index_ff;
   logic [FEAT_BITS-1:0]     value_ff;
   logic [BUTTON_BITS-1:0]   exp_ff;
   logic                     last_ff;
   logic                     load, emit, single, last;

   assign load   = !out_valid_ff || rsp_pop;
   assign emit   = load && !q_rd.empty;
   assign single = (q_rd.head.kind != KIND_FEATURE);
   assign last   = single || (idx_ff == FEAT_IDX_BITS'(FEAT_COUNT - 1));
   assign q_pop  = emit && last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = !q_rd.empty;
      end
      if (emit) begin
         idx_in = last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= q_rd.head.kind;
         index_ff <= single ? '0 : idx_ff;
         value_ff <= single ? '0 : q_rd.head.feat[idx_ff];
         exp_ff   <= q_rd.head.exp_button;
         last_ff  <= last;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_feature_index   = index_ff;
   assign rsp_feature_value   = value_ff;
   assign rsp_expected_button = exp_ff;
   assign rsp_last_item       = last_ff;

endmodule

/* design/keypress_sequence_timing_extractor_top.sv */
// Top level of the keypress sequence timing extractor: CSR registers and
// wiring of kste_front, kste_queue and kste_back. Uses kste_pkg.
//
//   channel  handshake             payload
//   req      push / full           button, pressed, time_ms
//   rsp      empty / pop           result_kind, feature_index, feature_value,
//                                  expected_button, last_item
//   csr      valid / ready         index, data (ready is always high)
//
// The front end takes one request per cycle while the job queue has room.
// A wrong-button or bad-sample request yields a single result item from the back
// end; a completed run with every span in range yields seven items, which the
// output register passes on one at a time, so completing runs bound the rate.
// Reset is synchronous: it clears position, pressed flags, last-edge stamps,
// the queue and the output valid; press and release stamps are not cleared.
// Full rises only when both queue slots hold jobs; a stalled rsp side holds
// the back end but not requests that produce no result until the queue fills.
module keypress_sequence_timing_extractor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [kste_pkg::BUTTON_BITS-1:0]   req_button,
   input  logic                               req_pressed,
   input  logic [kste_pkg::STAMP_BITS-1:0]    req_time_ms,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [kste_pkg::KIND_BITS-1:0]     rsp_result_kind,
   output logic [kste_pkg::FEAT_IDX_BITS-1:0] rsp_feature_index,
   output logic [kste_pkg::FEAT_BITS-1:0]     rsp_feature_value,
   output logic [kste_pkg::BUTTON_BITS-1:0]   rsp_expected_button,
   output logic                               rsp_last_item,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kste_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [kste_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import kste_pkg::*;

   cfg_type  cfg_ff;
   q_wr_type q_wr;
   q_rd_type q_rd;
   logic     q_full, q_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_gap <= DEBOUNCE_RESET;
         cfg_ff.feat_min     <= FEAT_MIN_RESET;
         cfg_ff.feat_max     <= FEAT_MAX_RESET;
         cfg_ff.exp_seq      <= EXP_SEQ_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE: cfg_ff.debounce_gap <= csr_data[FEAT_BITS-1:0];
            CSR_FEAT_MIN: cfg_ff.feat_min     <= csr_data[FEAT_BITS-1:0];
            CSR_FEAT_MAX: cfg_ff.feat_max     <= csr_data[FEAT_BITS-1:0];
            CSR_EXP_SEQ:  cfg_ff.exp_seq      <= csr_data[SEQ_CFG_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   kste_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_button  (req_button),
      .req_pressed (req_pressed),
      .req_time_ms (req_time_ms),
      .q_full      (q_full),
      .q_wr        (q_wr)
   );

   kste_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_rd   (q_rd)
   );

   kste_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_rd                (q_rd),
      .q_pop               (q_pop),
      .rsp_pop             (rsp_pop),
      .rsp_empty           (rsp_empty),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_feature_index   (rsp_feature_index),
      .rsp_feature_value   (rsp_feature_value),
      .rsp_expected_button (rsp_expected_button),
      .rsp_last_item       (rsp_last_item)
   );

endmodule

/* tb/sv/keypress_timing_checker.sv */
// Scoreboard for the keypress sequence timing extractor: watches the request,
// result and register channels, predicts every result and compares in order.
// Depends on kste_pkg for widths, result kinds and register indexes.
module keypress_timing_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   input  logic                               req_full,
   input  logic [kste_pkg::BUTTON_BITS-1:0]   req_button,
   input  logic                               req_pressed,
   input  logic [kste_pkg::STAMP_BITS-1:0]    req_time_ms,
   input  logic                               rsp_empty,
   input  logic                               rsp_pop,
   input  logic [kste_pkg::KIND_BITS-1:0]     rsp_result_kind,
   input  logic [kste_pkg::FEAT_IDX_BITS-1:0] rsp_feature_index,
   input  logic [kste_pkg::FEAT_BITS-1:0]     rsp_feature_value,
   input  logic [kste_pkg::BUTTON_BITS-1:0]   rsp_expected_button,
   input  logic                               rsp_last_item,
   input  logic                               csr_valid,
   input  logic                               csr_ready,
   input  logic [kste_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [kste_pkg::CSR_DATA_BITS-1:0] csr_data,
   output int                                 pending,
   output int                                 mismatches,
   output int                                 timing_results,
   output int                                 bad_results,
   output int                                 wrong_results
);
   import kste_pkg::*;

   typedef struct {
      kind_type                 kind;
      logic [FEAT_IDX_BITS-1:0] index;
      logic [FEAT_BITS-1:0]     value;
      logic [BUTTON_BITS-1:0]   button;
      logic                     last;
   } timing_report_type;

   timing_report_type awaited_reports [$];

   logic [FEAT_BITS-1:0]    cfg_debounce;
   logic [FEAT_BITS-1:0]    cfg_min;
   logic [FEAT_BITS-1:0]    cfg_max;
   logic [SEQ_CFG_BITS-1:0] cfg_seq;

   int                  track_pos;
   logic [STAMP_BITS-1:0] press_at      [SEQ_LEN];
   logic [STAMP_BITS-1:0] release_at    [SEQ_LEN];
   logic                  press_flag    [SEQ_LEN];
   logic [STAMP_BITS-1:0] last_key_time [BUTTON_COUNT];

   function automatic void queue_report(input kind_type kind, input int idx,
                                        input logic [FEAT_BITS-1:0] val,
                                        input logic [BUTTON_BITS-1:0] btn,
                                        input logic last);
      timing_report_type r;
      r.kind   = kind;
      r.index  = FEAT_IDX_BITS'(idx);
      r.value  = val;
      r.button = btn;
      r.last   = last;
      awaited_reports.push_back(r);
   endfunction

   // A span is usable only when it runs forward and lies in (min, max].
   function automatic logic span_ok(input logic [STAMP_BITS-1:0] from_t,
                                    input logic [STAMP_BITS-1:0] to_t,
                                    output logic [STAMP_BITS-1:0] span);
      span = to_t - from_t;
      return to_t >= from_t && span > cfg_min && span <= cfg_max;
   endfunction

   function automatic void extract_timings(input logic [BUTTON_BITS-1:0] btn,
                                           input logic lvl,
                                           input logic [STAMP_BITS-1:0] now);
      logic [BUTTON_BITS-1:0] want;
      logic [STAMP_BITS-1:0]  spans [FEAT_COUNT];
      logic                   all_ok;
      if (track_pos >= SEQ_LEN)
         track_pos = 0;
      want = cfg_seq[SEQ_SLOT_BITS*track_pos +: SEQ_SLOT_BITS];
      if (btn != want) begin
         // press flags survive this; only the position goes back
         track_pos = 0;
         queue_report(KIND_WRONG, 0, '0, want, 1'b1);
         return;
      end
      if (now < last_key_time[btn] || now - last_key_time[btn] < cfg_debounce)
         return;
      last_key_time[btn] = now;
      if (lvl) begin
         press_at[track_pos]   = now;
         press_flag[track_pos] = 1'b1;
         return;
      end
      if (!press_flag[track_pos])
         return;
      release_at[track_pos] = now;
      track_pos++;
      if (track_pos < SEQ_LEN)
         return;
      all_ok = 1'b1;
      for (int i = 0; i < SEQ_LEN; i++)
         if (!span_ok(press_at[i], release_at[i], spans[i]))
            all_ok = 1'b0;
      for (int i = 0; i + 1 < SEQ_LEN; i++)
         if (!span_ok(release_at[i], press_at[i + 1], spans[SEQ_LEN + i]))
            all_ok = 1'b0;
      track_pos = 0;
      for (int i = 0; i < SEQ_LEN; i++) begin
         press_at[i]   = '0;
         release_at[i] = '0;
         press_flag[i] = 1'b0;
      end
      if (!all_ok)
         queue_report(KIND_BAD, 0, '0, '0, 1'b1);
      else
         for (int i = 0; i < FEAT_COUNT; i++)
            queue_report(KIND_FEATURE, i, spans[i][FEAT_BITS-1:0], '0, i == FEAT_COUNT - 1);
   endfunction

   function automatic void compare_field(input string field,
                                         input logic [FEAT_BITS-1:0] want,
                                         input logic [FEAT_BITS-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void check_result();
      timing_report_type want;
      if (awaited_reports.size() == 0) begin
         $display("%0t: result expected none, got kind %0d index %0d value %0d",
                  $time, rsp_result_kind, rsp_feature_index, rsp_feature_value);
         mismatches++;
         return;
      end
      want = awaited_reports.pop_front();
      compare_field("result_kind", want.kind, rsp_result_kind);
      compare_field("feature_index", want.index, rsp_feature_index);
      compare_field("feature_value", want.value, rsp_feature_value);
      compare_field("expected_button", want.button, rsp_expected_button);
      compare_field("last_item", want.last, rsp_last_item);
      if (rsp_result_kind == KIND_FEATURE)
         timing_results++;
      else if (rsp_result_kind == KIND_BAD)
         bad_results++;
      else
         wrong_results++;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         track_pos = 0;
         for (int i = 0; i < SEQ_LEN; i++) begin
            press_at[i]   = '0;
            release_at[i] = '0;
            press_flag[i] = 1'b0;
         end
         for (int i = 0; i < BUTTON_COUNT; i++)
            last_key_time[i] = '0;
         cfg_debounce = DEBOUNCE_RESET;
         cfg_min      = FEAT_MIN_RESET;
         cfg_max      = FEAT_MAX_RESET;
         cfg_seq      = EXP_SEQ_RESET;
         awaited_reports.delete();
      end else begin
         if (csr_valid && csr_ready)
            case (csr_index)
               CSR_DEBOUNCE: cfg_debounce = csr_data;
               CSR_FEAT_MIN: cfg_min      = csr_data;
               CSR_FEAT_MAX: cfg_max      = csr_data;
               CSR_EXP_SEQ:  cfg_seq      = csr_data[SEQ_CFG_BITS-1:0];
               default: begin
               end
            endcase
         // check the outgoing result before predicting from this edge's request
         if (rsp_pop && !rsp_empty)
            check_result();
         if (req_push && !req_full)
            extract_timings(req_button, req_pressed, req_time_ms);
      end
      pending = awaited_reports.size();
   end

endmodule

/* tb/sv/keypress_sequence_timing_extractor_top_tb.sv */
// Testbench top for the keypress sequence timing extractor: clock, reset,
// key edge stimulus, register settings, result stalls and the verdict.
// Depends on kste_pkg, the block and keypress_timing_checker.
module keypress_sequence_timing_extractor_top_tb;
   import kste_pkg::*;

   localparam int PHASES          = 8;
   localparam int EDGES_PER_PHASE = 27;
   localparam int SETTLE_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT  = 600;

   logic                     clock;
   logic                     reset;
   logic                     req_push;
   logic                     req_full;
   logic [BUTTON_BITS-1:0]   req_button;
   logic                     req_pressed;
   logic [STAMP_BITS-1:0]    req_time_ms;
   logic                     rsp_empty;
   logic                     rsp_pop;
   logic [KIND_BITS-1:0]     rsp_result_kind;
   logic [FEAT_IDX_BITS-1:0] rsp_feature_index;
   logic [FEAT_BITS-1:0]     rsp_feature_value;
   logic [BUTTON_BITS-1:0]   rsp_expected_button;
   logic                     rsp_last_item;
   logic                     csr_valid;
   logic                     csr_ready;
   csr_index_type            csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   int pending;
   int mismatches;
   int timing_results;
   int bad_results;
   int wrong_results;

   logic [STAMP_BITS-1:0]   stamp;
   logic [FEAT_BITS-1:0]    debounce_set;
   logic [FEAT_BITS-1:0]    min_set;
   logic [FEAT_BITS-1:0]    max_set;
   logic [SEQ_CFG_BITS-1:0] seq_set;
   bit                      idling_on;
   int                      stall_left;
   int                      idle_cycles;
   int                      edges_sent;
   int                      phase_edges;

   keypress_sequence_timing_extractor_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_button          (req_button),
      .req_pressed         (req_pressed),
      .req_time_ms         (req_time_ms),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_feature_index   (rsp_feature_index),
      .rsp_feature_value   (rsp_feature_value),
      .rsp_expected_button (rsp_expected_button),
      .rsp_last_item       (rsp_last_item),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   keypress_timing_checker timing_check (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_button          (req_button),
      .req_pressed         (req_pressed),
      .req_time_ms         (req_time_ms),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_feature_index   (rsp_feature_index),
      .rsp_feature_value   (rsp_feature_value),
      .rsp_expected_button (rsp_expected_button),
      .rsp_last_item       (rsp_last_item),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .pending             (pending),
      .mismatches          (mismatches),
      .timing_results      (timing_results),
      .bad_results         (bad_results),
      .wrong_results       (wrong_results)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Advance the stamp by step and hold the request until it is taken.
   task automatic send_key(input logic [BUTTON_BITS-1:0] key, input logic level,
                           input longint step);
      logic took;
      stamp = STAMP_BITS'(longint'(stamp) + step);
      req_push    <= 1'b1;
      req_button  <= key;
      req_pressed <= level;
      req_time_ms <= stamp;
      do begin
         @(negedge clock);
         took = !req_full;
         @(posedge clock);
      end while (!took);
      edges_sent++;
      phase_edges++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic program_settings(input logic [FEAT_BITS-1:0] deb,
                                   input logic [FEAT_BITS-1:0] lo,
                                   input logic [FEAT_BITS-1:0] hi,
                                   input logic [SEQ_CFG_BITS-1:0] order);
      csr_index_type        regs [4] = '{CSR_DEBOUNCE, CSR_FEAT_MIN, CSR_FEAT_MAX, CSR_EXP_SEQ};
      logic [FEAT_BITS-1:0] vals [4];
      logic                 took;
      vals = '{deb, lo, hi, FEAT_BITS'(order)};
      debounce_set = deb;
      min_set      = lo;
      max_set      = hi;
      seq_set      = order;
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data  <= vals[i];
         do begin
            @(negedge clock);
            took = csr_ready;
            @(posedge clock);
         end while (!took);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop the request line, wait out every result, then let the pipe empty.
   task automatic wait_drained();
      req_push <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly an in-range interval, now and then a boundary, a too-soon,
   // a backward or an oversized one.
   function automatic longint pick_gap(input bit same_key);
      longint lo;
      longint hi;
      lo = longint'(min_set) + 1;
      if (same_key && longint'(debounce_set) > lo)
         lo = longint'(debounce_set);
      hi = longint'(max_set);
      if (hi < lo)
         hi = lo;
      case ($urandom_range(0, 15))
         0:       return longint'(min_set);
         1:       return longint'(min_set) + 1;
         2:       return longint'(max_set);
         3:       return longint'(max_set) + 1;
         4:       return longint'($urandom_range(0, 32'(debounce_set)));
         5:       return -longint'($urandom_range(1, 500));
         6:       return longint'($urandom_range(65536, 200000));
         default: return longint'($urandom_range(32'(lo), 32'(hi)));
      endcase
   endfunction

   task automatic play_sequence(input int edge_count);
      logic [BUTTON_BITS-1:0] key;
      longint                 step;
      for (int k = 0; k < edge_count; k++) begin
         key = seq_set[SEQ_SLOT_BITS*(k/2) +: SEQ_SLOT_BITS];
         if (k == 0)
            step = longint'(debounce_set) + longint'($urandom_range(1, 2000));
         else if (k % 2 == 1)
            step = pick_gap(1'b1);
         else
            step = pick_gap(key == seq_set[SEQ_SLOT_BITS*(k/2 - 1) +: SEQ_SLOT_BITS]);
         send_key(key, k % 2 == 0, step);
      end
      // knock a partial run back to the start with a key not expected there
      if (edge_count < 2*SEQ_LEN)
         send_key(BUTTON_BITS'(seq_set[SEQ_SLOT_BITS*(edge_count/2) +: SEQ_SLOT_BITS]
                               + 1'b1),
                  1'($urandom_range(0, 1)), longint'($urandom_range(0, 100)));
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 3);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int pick;
      reset       <= 1'b1;
      req_push    <= 1'b0;
      req_button  <= '0;
      req_pressed <= 1'b0;
      req_time_ms <= '0;
      rsp_pop     <= 1'b0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_DEBOUNCE;
      csr_data    <= '0;
      stamp        = 40'd1_000_000;
      debounce_set = DEBOUNCE_RESET;
      min_set      = FEAT_MIN_RESET;
      max_set      = FEAT_MAX_RESET;
      seq_set      = EXP_SEQ_RESET;
      idling_on    = 1'b1;
      stall_left   = 0;
      idle_cycles  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // clean run: every hold at the upper limit, every flight just above the lower
      send_key(2'd0, 1'b1, 0);
      send_key(2'd0, 1'b0, 5000);
      send_key(2'd1, 1'b1, 6);
      send_key(2'd1, 1'b0, 5000);
      send_key(2'd2, 1'b1, 6);
      send_key(2'd2, 1'b0, 5000);
      send_key(2'd3, 1'b1, 6);
      send_key(2'd3, 1'b0, 5000);
      // wrong key at the start
      send_key(2'd3, 1'b1, 1000);
      // release too soon is dropped, one exactly at the debounce time advances
      send_key(2'd0, 1'b1, 100);
      send_key(2'd0, 1'b0, 10);
      send_key(2'd0, 1'b0, 40);
      // wrong key resets the position but the earlier press still counts
      send_key(2'd0, 1'b1, 100);
      send_key(2'd0, 1'b0, 100);
      // release with no press at this position
      send_key(2'd1, 1'b0, 100);
      // stamp behind the key's last edge
      send_key(2'd1, 1'b1, -30);
      // finish with one hold above the limit: bad sample
      send_key(2'd1, 1'b1, 100);
      send_key(2'd1, 1'b0, 5001);
      send_key(2'd2, 1'b1, 10);
      send_key(2'd2, 1'b0, 100);
      send_key(2'd3, 1'b1, 10);
      send_key(2'd3, 1'b0, 100);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1:        program_settings(16'd0, 16'd0, 16'hFFFF, 8'h00);
               2:        program_settings(16'hFFFF, FEAT_BITS'($urandom_range(0, 1000)),
                                          16'hFFFF, 8'hFF);
               3:        program_settings(FEAT_BITS'($urandom_range(1, 100)), 16'd5000,
                                          16'd100, SEQ_CFG_BITS'($urandom()));
               4:        program_settings(16'd10, 16'd300, 16'd300,
                                          SEQ_CFG_BITS'($urandom()));
               PHASES-1: program_settings(DEBOUNCE_RESET, FEAT_MIN_RESET, FEAT_MAX_RESET,
                                          EXP_SEQ_RESET);
               default:  program_settings(FEAT_BITS'($urandom_range(0, 200)),
                                          FEAT_BITS'($urandom_range(0, 100)),
                                          FEAT_BITS'($urandom_range(200, 8000)),
                                          SEQ_CFG_BITS'($urandom()));
            endcase
         end
         // move time forward only, so old last-edge stamps never block a phase
         if (phase == PHASES - 1) begin
            idling_on = 1'b0;
            stamp = 40'hFF_FF00_0000 + STAMP_BITS'($urandom_range(0, 1 << 20));
         end else begin
            stamp = stamp + STAMP_BITS'($urandom());
         end
         phase_edges = 0;
         while (phase_edges < EDGES_PER_PHASE) begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
               play_sequence(2*SEQ_LEN);
            else if (pick < 17)
               play_sequence($urandom_range(1, 2*SEQ_LEN - 1));
            else
               send_key(BUTTON_BITS'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        pick_gap(1'b0));
         end
      end

      wait_drained();
      $display("Sent %0d key edges under %0d register settings, with stalls on both sides",
               edges_sent, PHASES);
      $display("Checked %0d timing, %0d bad-sample and %0d wrong-key results",
               timing_results, bad_results, wrong_results);
      if (mismatches == 0 && pending == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
